FILE: hw/rtl/pfs_pkg.sv
// Shared types, sizes and dominance compare for the Pareto front sorter.
package pfs_pkg;

  localparam int MaxItems = 64;
  localparam int MaxObj   = 4;
  localparam int IdxW     = 6;
  localparam int CntW     = 7;
  localparam int ObjW     = 32;

  localparam logic [1:0] CFG_STOP_COUNT = 2'd0;
  localparam logic [1:0] CFG_NUM_OBJ    = 2'd1;
  localparam logic [1:0] CFG_MAX_MASK   = 2'd2;

  typedef logic [MaxObj-1:0][ObjW-1:0] obj_row_t;

  // Objective memory write from the loader.
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    obj_row_t        row;
  } pfs_wr_t;

  // Settings as seen by the sort engine (objective count already clamped).
  typedef struct packed {
    logic [CntW-1:0] stop_count;
    logic [2:0]      num_obj;
    logic [MaxObj-1:0] max_mask;
  } pfs_cfg_t;

  // Returns {x beats y, y beats x}.
  function automatic logic [1:0] dominance(obj_row_t x, obj_row_t y, logic [2:0] n,
                                           logic [MaxObj-1:0] mask);
    logic any_win;
    logic any_lose;
    logic lt;
    logic gt;
    any_win  = 1'b0;
    any_lose = 1'b0;
    for (int k = 0; k < MaxObj; k++) begin
      lt = $signed(x[k]) < $signed(y[k]);
      gt = $signed(x[k]) > $signed(y[k]);
      if (3'(k) < n) begin
        if (mask[k]) begin
          any_win  = any_win | gt;
          any_lose = any_lose | lt;
        end else begin
          any_win  = any_win | lt;
          any_lose = any_lose | gt;
        end
      end
    end
    return {any_win & ~any_lose, any_lose & ~any_win};
  endfunction

endpackage

FILE: hw/rtl/pfs_loader.sv
// Front part: takes items, writes the objective memory, queues a sort job on the last item.
module pfs_loader (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [31:0]              obj_a,
  input  logic [31:0]              obj_b,
  input  logic [31:0]              obj_c,
  input  logic [31:0]              obj_d,
  input  logic                     final_item,
  input  logic                     sort_pending,
  output pfs_pkg::pfs_wr_t         wr,
  output logic                     job_push,
  output logic [pfs_pkg::CntW-1:0] job_count
);

  logic [pfs_pkg::CntW-1:0] count;
  logic                     room;
  logic                     accept;

  assign in_stall = sort_pending;
  assign accept   = in_valid & ~in_stall;
  assign room     = count < pfs_pkg::CntW'(pfs_pkg::MaxItems);

  assign wr.we   = accept & room;
  assign wr.addr = count[pfs_pkg::IdxW-1:0];
  assign wr.row  = {obj_d, obj_c, obj_b, obj_a};

  assign job_push  = accept & final_item;
  assign job_count = room ? count + 1'b1 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (final_item) count <= '0;
      else if (room)  count <= count + 1'b1;
    end
  end

endmodule

FILE: hw/rtl/pfs_job_fifo.sv
// Two-entry queue of sort jobs (population sizes) between loader and sort engine.
module pfs_job_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [pfs_pkg::CntW-1:0] push_data,
  input  logic                     pop,
  output logic [pfs_pkg::CntW-1:0] head,
  output logic                     empty
);

  logic [pfs_pkg::CntW-1:0] slot [2];
  logic                     rd_ptr;
  logic                     wr_ptr;
  logic [1:0]               fill;
  logic                     do_push;
  logic                     do_pop;

  assign empty   = fill == 2'd0;
  assign head    = slot[rd_ptr];
  assign do_push = push & (fill != 2'd2);
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: hw/rtl/pfs_arena.sv
// Back part: objective memory, arena front search sequencer and result register.
module pfs_arena (
  input  logic                     clk,
  input  logic                     rst,
  input  pfs_pkg::pfs_wr_t         wr,
  input  pfs_pkg::pfs_cfg_t        cfg,
  input  logic                     job_ready,
  input  logic [pfs_pkg::CntW-1:0] job_count,
  output logic                     job_pop,
  output logic                     busy,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [5:0]               member_index,
  output logic [5:0]               front_number,
  output logic                     last_result
);

  localparam int IdxW = pfs_pkg::IdxW;
  localparam int CntW = pfs_pkg::CntW;
  localparam int N    = pfs_pkg::MaxItems;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_BUILD    = 5'd1;
  localparam logic [4:0] ST_POP_RD   = 5'd2;
  localparam logic [4:0] ST_POP_OBJ  = 5'd3;
  localparam logic [4:0] ST_POP_X    = 5'd4;
  localparam logic [4:0] ST_SCAN_RD  = 5'd5;
  localparam logic [4:0] ST_SCAN_OBJ = 5'd6;
  localparam logic [4:0] ST_SCAN_CMP = 5'd7;
  localparam logic [4:0] ST_CP_RD    = 5'd8;
  localparam logic [4:0] ST_CP_WR    = 5'd9;
  localparam logic [4:0] ST_HELD_RD  = 5'd10;
  localparam logic [4:0] ST_HELD_OBJ = 5'd11;
  localparam logic [4:0] ST_HELD_CMP = 5'd12;
  localparam logic [4:0] ST_CAND_RD  = 5'd13;
  localparam logic [4:0] ST_CAND_WR  = 5'd14;
  localparam logic [4:0] ST_CONFIRM  = 5'd15;
  localparam logic [4:0] ST_FRONT_END = 5'd16;

  // memories
  pfs_pkg::obj_row_t obj_mem [N];
  logic [IdxW-1:0]   work_mem [N];
  logic [IdxW-1:0]   held_mem [N];
  logic [IdxW-1:0]   cand_mem [N];

  pfs_pkg::obj_row_t obj_rdata;
  logic [IdxW-1:0]   work_rdata;
  logic [IdxW-1:0]   held_rdata;
  logic [IdxW-1:0]   cand_rdata;

  logic [IdxW-1:0] obj_raddr, work_raddr, held_raddr, cand_raddr;
  logic            work_we, held_we, cand_we;
  logic [IdxW-1:0] work_waddr, work_wdata, held_waddr, held_wdata;

  logic [4:0]        state;
  logic [CntW-1:0]   pop_n, i, j, wn, hn, cn, qn, emitted;
  logic [N-1:0]      assigned;
  logic [IdxW-1:0]   x, y, pend;
  logic              pend_valid;
  pfs_pkg::obj_row_t x_row;
  logic [5:0]        front;
  logic [1:0]        dom;
  logic              out_free;
  logic              stop;
  logic              emit;

  assign busy     = state != ST_IDLE;
  assign job_pop  = (state == ST_IDLE) & job_ready;
  assign out_free = ~out_valid | ~out_stall;
  assign dom      = pfs_pkg::dominance(x_row, obj_rdata, cfg.num_obj, cfg.max_mask);
  assign stop     = (emitted >= cfg.stop_count) | (emitted == pop_n);
  // a result item leaves the sequencer this cycle if the register is free
  assign emit     = ((state == ST_CONFIRM) & pend_valid) | (state == ST_FRONT_END);

  always_comb begin
    obj_raddr  = work_rdata;
    work_raddr = i[IdxW-1:0];
    held_raddr = i[IdxW-1:0];
    cand_raddr = j[IdxW-1:0];
    work_we    = 1'b0;
    work_waddr = qn[IdxW-1:0];
    work_wdata = y;
    held_we    = 1'b0;
    held_waddr = hn[IdxW-1:0];
    held_wdata = cand_rdata;
    cand_we    = 1'b0;
    case (state)
      ST_BUILD: begin
        work_we    = (i != pop_n) & ~assigned[i[IdxW-1:0]];
        work_waddr = wn[IdxW-1:0];
        work_wdata = i[IdxW-1:0];
      end
      ST_POP_RD:   work_raddr = 6'(wn - 1'b1);
      ST_HELD_OBJ: obj_raddr = held_rdata;
      ST_SCAN_CMP: cand_we = ~dom[1] & ~dom[0];
      ST_CP_WR:    held_we = 1'b1;
      ST_HELD_CMP: work_we = ~dom[1];
      ST_CAND_WR: begin
        work_we    = 1'b1;
        work_wdata = cand_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.we) obj_mem[wr.addr] <= wr.row;
    obj_rdata <= obj_mem[obj_raddr];
  end

  always_ff @(posedge clk) begin
    if (work_we) work_mem[work_waddr] <= work_wdata;
    work_rdata <= work_mem[work_raddr];
  end

  always_ff @(posedge clk) begin
    if (held_we) held_mem[held_waddr] <= held_wdata;
    held_rdata <= held_mem[held_raddr];
  end

  always_ff @(posedge clk) begin
    if (cand_we) cand_mem[cn[IdxW-1:0]] <= y;
    cand_rdata <= cand_mem[cand_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      assigned   <= '0;
    end else begin
      if (out_free) out_valid <= emit;
      case (state)
        ST_IDLE: begin
          if (job_ready) begin
            pop_n      <= job_count;
            assigned   <= '0;
            front      <= '0;
            emitted    <= '0;
            pend_valid <= 1'b0;
            i          <= '0;
            wn         <= '0;
            state      <= ST_BUILD;
          end
        end
        ST_BUILD: begin
          if (i == pop_n) begin
            state <= (wn == '0) ? ST_IDLE : ST_POP_RD;
          end else begin
            if (work_we) wn <= wn + 1'b1;
            i <= i + 1'b1;
          end
        end
        ST_POP_RD: begin
          wn    <= wn - 1'b1;
          hn    <= '0;
          cn    <= '0;
          qn    <= '0;
          state <= ST_POP_OBJ;
        end
        ST_POP_OBJ: begin
          x     <= work_rdata;
          state <= ST_POP_X;
        end
        ST_POP_X: begin
          x_row <= obj_rdata;
          i     <= '0;
          state <= ST_SCAN_RD;
        end
        ST_SCAN_RD: begin
          if (i == wn) begin
            i     <= '0;
            state <= ST_HELD_RD;
          end else begin
            state <= ST_SCAN_OBJ;
          end
        end
        ST_SCAN_OBJ: begin
          y     <= work_rdata;
          state <= ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          i <= i + 1'b1;
          if (dom[1]) begin
            state <= ST_SCAN_RD;
          end else if (dom[0]) begin
            // challenger wins: pending candidates move to the held list
            x     <= y;
            x_row <= obj_rdata;
            j     <= '0;
            state <= ST_CP_RD;
          end else begin
            cn    <= cn + 1'b1;
            state <= ST_SCAN_RD;
          end
        end
        ST_CP_RD: begin
          if (j == cn) begin
            cn    <= '0;
            state <= ST_SCAN_RD;
          end else begin
            state <= ST_CP_WR;
          end
        end
        ST_CP_WR: begin
          hn    <= hn + 1'b1;
          j     <= j + 1'b1;
          state <= ST_CP_RD;
        end
        ST_HELD_RD: begin
          if (i == hn) begin
            j     <= '0;
            state <= ST_CAND_RD;
          end else begin
            state <= ST_HELD_OBJ;
          end
        end
        ST_HELD_OBJ: begin
          y     <= held_rdata;
          state <= ST_HELD_CMP;
        end
        ST_HELD_CMP: begin
          if (~dom[1]) qn <= qn + 1'b1;
          i     <= i + 1'b1;
          state <= ST_HELD_RD;
        end
        ST_CAND_RD: begin
          state <= (j == cn) ? ST_CONFIRM : ST_CAND_WR;
        end
        ST_CAND_WR: begin
          qn    <= qn + 1'b1;
          j     <= j + 1'b1;
          state <= ST_CAND_RD;
        end
        ST_CONFIRM: begin
          if (~pend_valid | out_free) begin
            if (pend_valid) begin
              member_index <= pend;
              front_number <= front;
              last_result  <= 1'b0;
            end
            pend        <= x;
            pend_valid  <= 1'b1;
            assigned[x] <= 1'b1;
            emitted     <= emitted + 1'b1;
            if (qn == '0) begin
              state <= ST_FRONT_END;
            end else begin
              wn    <= qn;
              state <= ST_POP_RD;
            end
          end
        end
        ST_FRONT_END: begin
          if (out_free) begin
            member_index <= pend;
            front_number <= front;
            last_result  <= stop;
            pend_valid   <= 1'b0;
            if (stop) begin
              state <= ST_IDLE;
            end else begin
              front <= front + 1'b1;
              i     <= '0;
              wn    <= '0;
              state <= ST_BUILD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pareto_front_sorter_unit.sv
// Top level of the Pareto front sorter: configuration registers and part wiring.
//
// Input channel (in_valid/in_stall): one item per solution, objectives obj_a..obj_d.
// Items are taken one per cycle while in_stall is low and written to the objective
// memory; the first 64 of a population are kept, later ones are dropped. An item
// with final_item set closes the population and queues a sort job; while a job
// is queued or being sorted, in_stall is high.
// Sort: arena-principle front search run by a sequencer over single-read-port
// memories. Each pairwise dominance test takes three steps (list read, objective
// read, compare).
// Output channel (out_valid/out_stall): one item per emitted member, with its
// load index, front number and last_result on the final one. A result register
// holds each item; when the receiver stalls the sequencer waits at the next
// emission, nothing is lost.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 stop_count,
// 1 num_objectives, 2 maximize_mask; other indexes are ignored. Write only when
// idle.
// Reset (rst, synchronous): clears the population, queue, sequencer and sets
// stop_count 32, num_objectives 2, maximize_mask 0. No memory clearing pass.
module pareto_front_sorter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] obj_a,
  input  logic [31:0] obj_b,
  input  logic [31:0] obj_c,
  input  logic [31:0] obj_d,
  input  logic        final_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  member_index,
  output logic [5:0]  front_number,
  output logic        last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [6:0] stop_count;
  logic [2:0] num_objectives;
  logic [3:0] maximize_mask;

  pfs_pkg::pfs_cfg_t        cfg;
  pfs_pkg::pfs_wr_t         wr;
  logic                     job_push, job_pop, job_empty, busy;
  logic [pfs_pkg::CntW-1:0] job_count, job_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count     <= 7'd32;
      num_objectives <= 3'd2;
      maximize_mask  <= 4'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfs_pkg::CFG_STOP_COUNT: stop_count     <= cfg_data;
        pfs_pkg::CFG_NUM_OBJ:    num_objectives <= cfg_data[2:0];
        pfs_pkg::CFG_MAX_MASK:   maximize_mask  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // zero counts as one objective, anything above four as four
  always_comb begin
    cfg.stop_count = stop_count;
    cfg.max_mask   = maximize_mask;
    if (num_objectives == 3'd0)      cfg.num_obj = 3'd1;
    else if (num_objectives > 3'd4)  cfg.num_obj = 3'd4;
    else                             cfg.num_obj = num_objectives;
  end

  pfs_loader u_loader (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .obj_a        (obj_a),
    .obj_b        (obj_b),
    .obj_c        (obj_c),
    .obj_d        (obj_d),
    .final_item   (final_item),
    .sort_pending (~job_empty | busy),
    .wr           (wr),
    .job_push     (job_push),
    .job_count    (job_count)
  );

  pfs_job_fifo u_job_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_count),
    .pop       (job_pop),
    .head      (job_head),
    .empty     (job_empty)
  );

  pfs_arena u_arena (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .cfg          (cfg),
    .job_ready    (~job_empty),
    .job_count    (job_head),
    .job_pop      (job_pop),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .member_index (member_index),
    .front_number (front_number),
    .last_result  (last_result)
  );

endmodule
